// File: sv/lbh_pkg.sv
// Shared types, constants and helper functions for the letter bigram histogram.
// No dependencies; imported by lbh_ctrl, lbh_datapath and letter_bigram_histogram.
`default_nettype none

package lbh_pkg;

   // table geometry
   localparam int SYMBOLS         = 28;
   localparam int CELLS           = SYMBOLS * SYMBOLS;
   localparam int CELL_ADDR_BITS  = $clog2(CELLS);
   localparam int SYM_BITS        = 5;
   localparam int DEFAULT_COUNT_BITS = 32;
   localparam int OUT_BITS        = 32;

   // symbol codes
   localparam logic [SYM_BITS-1:0] SYM_BOS   = 5'd26;
   localparam logic [SYM_BITS-1:0] SYM_EOS   = 5'd27;
   localparam logic [SYM_BITS-1:0] NO_LETTER = 5'd26;
   localparam logic [SYM_BITS-1:0] SYM_LAST  = 5'd27;

   // byte codes
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   // request kinds
   typedef enum logic [1:0] {
      ACT_FEED = 2'd0,
      ACT_END  = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // request taken this cycle
      logic clear_wr;   // write zero at the clear counter
      logic bump_wr;    // write incremented count back
      logic load_rsp;   // capture read data into the response register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last; // clear counter on the last cell
      logic bump_en;    // the offered request increments a cell
      logic is_read;    // the offered request is a table read
   } ctrl_sts_type;

   // case-folded letter index 0-25, else NO_LETTER
   function automatic logic [SYM_BITS-1:0] letter_of(input logic [7:0] b);
      logic [7:0] d;
      d = 8'd0;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         d = b - CHAR_UPPER_A;
         letter_of = d[SYM_BITS-1:0];
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
         d = b - CHAR_LOWER_A;
         letter_of = d[SYM_BITS-1:0];
      end else begin
         letter_of = NO_LETTER;
      end
   endfunction

   // row-major cell address, row * 28 + col
   function automatic logic [CELL_ADDR_BITS-1:0] cell_addr(
      input logic [SYM_BITS-1:0] row,
      input logic [SYM_BITS-1:0] col
   );
      logic [CELL_ADDR_BITS-1:0] r;
      r = CELL_ADDR_BITS'(row);
      cell_addr = (r << 4) + (r << 3) + (r << 2) + CELL_ADDR_BITS'(col);
   endfunction

endpackage

`default_nettype wire

// File: sv/lbh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lbh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 784
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/lbh_ctrl.sv
// Controller state machine: clear pass, request intake, count update, read reply.
// Depends on lbh_pkg.
`default_nettype none

module lbh_ctrl
   import lbh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_BUMP  = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // response register empties the same cycle it is taken
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // commands
   always_comb begin
      cmd.accept   = accept;
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.bump_wr  = (state_ff == ST_BUMP);
      cmd.load_rsp = (state_ff == ST_READ) && rsp_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (sts.bump_en)      state_in = ST_BUMP;
               else if (sts.is_read) state_in = ST_READ;
            end
         end
         ST_BUMP: state_in = ST_IDLE;
         ST_READ: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: sv/lbh_datapath.sv
// Datapath: word tracking, table addressing, saturating update, response data.
// Depends on lbh_pkg and lbh_ram.
`default_nettype none

module lbh_datapath
   import lbh_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [1:0]    action,
   input  wire logic [7:0]    data_byte,
   input  wire logic [4:0]    row_index,
   input  wire logic [4:0]    col_index,
   input  wire logic          csr_wr_en,
   input  wire logic          csr_wr_data,
   output logic [OUT_BITS-1:0] pair_count,
   input  wire ctrl_cmd_type  cmd,
   output ctrl_sts_type       sts
);

   // word state
   logic [SYM_BITS-1:0] last_sym_ff, last_sym_in;
   logic                word_start_ff, word_start_in;
   logic                cr_pending_ff, cr_pending_in;
   logic                header_done_ff, header_done_in;
   logic                skip_header_ff;

   // table access
   logic [CELL_ADDR_BITS-1:0] clr_cnt_ff;
   logic [CELL_ADDR_BITS-1:0] wr_addr_ff;
   logic                      rd_oob_ff;
   logic [OUT_BITS-1:0]       pair_count_ff;

   logic                      bump_en;
   logic [SYM_BITS-1:0]       bump_row, bump_col;
   logic                      is_read, rd_oob;
   logic [CELL_ADDR_BITS-1:0] bump_addr, read_addr, ram_rd_addr, ram_wr_addr;
   logic [COUNT_BITS-1:0]     ram_rd_data, ram_wr_data, count_inc;
   logic [OUT_BITS-1:0]       count_out;
   logic                      ram_wr_en;
   logic                      in_header;
   logic [SYM_BITS-1:0]       sym, eff_last;
   logic                      eff_start;
   action_type                act;

   assign act       = action_type'(action);
   assign in_header = skip_header_ff && !header_done_ff;
   assign sym       = letter_of(data_byte);
   // held carriage returns that are not trailing act as one non-letter
   assign eff_start = word_start_ff && !cr_pending_ff;
   assign eff_last  = cr_pending_ff ? NO_LETTER : last_sym_ff;

   // pair decode and next word state for the offered request
   always_comb begin
      bump_en        = 1'b0;
      bump_row       = last_sym_ff;
      bump_col       = SYM_EOS;
      last_sym_in    = last_sym_ff;
      word_start_in  = word_start_ff;
      cr_pending_in  = cr_pending_ff;
      header_done_in = header_done_ff;
      if (act == ACT_END || (act == ACT_FEED && data_byte == CHAR_LF)) begin
         // word close: last letter then EOS
         bump_en        = !in_header && !word_start_ff && (last_sym_ff < NO_LETTER);
         header_done_in = 1'b1;
         word_start_in  = 1'b1;
         last_sym_in    = NO_LETTER;
         cr_pending_in  = 1'b0;
      end else if (act == ACT_FEED && !in_header) begin
         if (data_byte == CHAR_CR) begin
            cr_pending_in = 1'b1;
         end else begin
            cr_pending_in = 1'b0;
            word_start_in = 1'b0;
            last_sym_in   = sym;
            bump_col      = sym;
            if (eff_start) begin
               bump_en  = (sym < NO_LETTER);
               bump_row = SYM_BOS;
            end else begin
               bump_en  = (eff_last < NO_LETTER) && (sym < NO_LETTER);
               bump_row = eff_last;
            end
         end
      end
   end

   assign is_read   = (act == ACT_READ);
   assign rd_oob    = (row_index > SYM_LAST) || (col_index > SYM_LAST);
   assign bump_addr = cell_addr(bump_row, bump_col);
   assign read_addr = rd_oob ? '0 : cell_addr(row_index, col_index);

   always_comb begin
      sts.clear_last = (clr_cnt_ff == CELL_ADDR_BITS'(CELLS - 1));
      sts.bump_en    = bump_en;
      sts.is_read    = is_read;
   end

   // saturating increment of the fetched count
   assign count_inc   = (&ram_rd_data) ? ram_rd_data : ram_rd_data + 1'b1;
   assign ram_rd_addr = is_read ? read_addr : bump_addr;
   assign ram_wr_en   = cmd.clear_wr || cmd.bump_wr;
   assign ram_wr_addr = cmd.clear_wr ? clr_cnt_ff : wr_addr_ff;
   assign ram_wr_data = cmd.clear_wr ? '0 : count_inc;

   lbh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (CELLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response width: low bits of the count, zero-extended when narrower
   generate
      if (COUNT_BITS >= OUT_BITS) begin : g_out_trunc
         assign count_out = ram_rd_data[OUT_BITS-1:0];
      end else begin : g_out_ext
         assign count_out = OUT_BITS'(ram_rd_data);
      end
   endgenerate

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sym_ff    <= NO_LETTER;
         word_start_ff  <= 1'b1;
         cr_pending_ff  <= 1'b0;
         header_done_ff <= 1'b0;
         skip_header_ff <= 1'b1;
         clr_cnt_ff     <= '0;
      end else begin
         if (cmd.accept) begin
            last_sym_ff    <= last_sym_in;
            word_start_ff  <= word_start_in;
            cr_pending_ff  <= cr_pending_in;
            header_done_ff <= header_done_in;
         end
         if (csr_wr_en) begin
            skip_header_ff <= csr_wr_data;
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         wr_addr_ff <= bump_addr;
         rd_oob_ff  <= rd_oob;
      end
      if (cmd.load_rsp) begin
         pair_count_ff <= rd_oob_ff ? '0 : count_out;
      end
   end

   assign pair_count = pair_count_ff;

endmodule

`default_nettype wire

// File: sv/letter_bigram_histogram.sv
// Letter bigram histogram: after reset the block clears its 784-cell count
// table, one cell per cycle, and takes no request until that pass ends;
// writes to skip_header are taken at any time. A feed or end request that
// causes no count change is done when it is accepted; one that increments a
// cell needs a read and then a write of the table memory. A read request
// loads its result into an output register, so the next request is taken
// while the result has not yet been collected; a second read waits only until
// that register is free. Counts saturate at all ones.
// Depends on lbh_pkg, lbh_ctrl, lbh_datapath and lbh_ram.
`default_nettype none

module letter_bigram_histogram
   import lbh_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] action, [9:2] data_byte, [14:10] row_index, [19:15] col_index, rest 0
   input  wire logic [23:0] req_tdata,
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] pair_count
   output logic [31:0]      rsp_tdata,
   // configuration: skip_header
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   lbh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lbh_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .action      (req_tdata[1:0]),
      .data_byte   (req_tdata[9:2]),
      .row_index   (req_tdata[14:10]),
      .col_index   (req_tdata[19:15]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pair_count  (rsp_tdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking bench for letter_bigram_histogram: text, end and read requests are
// driven under random back-pressure and each read count is checked against a model.
// Depends on lbh_pkg and the letter_bigram_histogram RTL.
`default_nettype none

module tb;
   import lbh_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 8;
   localparam int PHASE_ITEMS  = 510;

   // bigram count model and store of pending read counts
   class bigram_scoreboard;
      bit [31:0]         counts [SYMBOLS][SYMBOLS];
      bit [SYM_BITS-1:0] prev_sym        = NO_LETTER;
      bit                at_word_start   = 1'b1;
      bit                cr_held         = 1'b0;
      bit                header_seen     = 1'b0;
      bit                skip_first_line = 1'b1;
      bit [31:0]         pending_counts [$];
      int unsigned       errors          = 0;

      function automatic bit [SYM_BITS-1:0] fold_letter(bit [7:0] b);
         bit [7:0] lower;
         // setting bit 5 folds A-Z onto a-z and leaves no other byte in a-z
         lower = b | 8'h20;
         if (lower >= CHAR_LOWER_A && lower <= CHAR_LOWER_Z)
            return SYM_BITS'(lower - CHAR_LOWER_A);
         return NO_LETTER;
      endfunction

      function void bump(bit [SYM_BITS-1:0] r, bit [SYM_BITS-1:0] c);
         if (counts[r][c] != '1)
            counts[r][c]++;
      endfunction

      function void close_word();
         if (!(skip_first_line && !header_seen) && !at_word_start &&
             prev_sym < NO_LETTER)
            bump(prev_sym, SYM_EOS);
         header_seen   = 1'b1;
         at_word_start = 1'b1;
         prev_sym      = NO_LETTER;
         cr_held       = 1'b0;
      endfunction

      function void take_byte(bit [7:0] b);
         bit [SYM_BITS-1:0] sym;
         if (b == CHAR_LF) begin
            close_word();
            return;
         end
         if (skip_first_line && !header_seen)
            return;
         // carriage returns wait until we know whether they trail the line
         if (b == CHAR_CR) begin
            cr_held = 1'b1;
            return;
         end
         if (cr_held) begin
            at_word_start = 1'b0;
            prev_sym      = NO_LETTER;
            cr_held       = 1'b0;
         end
         sym = fold_letter(b);
         if (at_word_start) begin
            if (sym < NO_LETTER)
               bump(SYM_BOS, sym);
            at_word_start = 1'b0;
         end else if (prev_sym < NO_LETTER && sym < NO_LETTER) begin
            bump(prev_sym, sym);
         end
         prev_sym = sym;
      endfunction

      function void note_request(action_type act, bit [7:0] b,
                                 bit [SYM_BITS-1:0] row, bit [SYM_BITS-1:0] col);
         case (act)
            ACT_FEED: take_byte(b);
            ACT_END:  close_word();
            ACT_READ: begin
               if (row < SYMBOLS && col < SYMBOLS)
                  pending_counts.push_back(counts[row][col]);
               else
                  pending_counts.push_back('0);
            end
            default: ;
         endcase
      endfunction

      function void check_result(bit [31:0] got);
         bit [31:0] want;
         if (pending_counts.size() == 0) begin
            $error("unexpected response, pair_count actual %0d", got);
            errors++;
            return;
         end
         want = pending_counts.pop_front();
         if (got !== want) begin
            $error("pair_count mismatch: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   bigram_scoreboard sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned sent_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned hold_count    = 0;
   logic        hold_go       = 1'b0;

   letter_bigram_histogram u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // response side: check, then pick next ready (long hold when asked)
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      if (hold_go && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // one request, with random idle cycles ahead of it
   task automatic send_req(input action_type act, input logic [7:0] b,
                           input logic [4:0] row, input logic [4:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, col, row, b, act};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(act, b, row, col);
      sent_count++;
   endtask

   // byte with junk in the unused index fields
   task automatic feed(input logic [7:0] b);
      send_req(ACT_FEED, b, 5'($urandom_range(31)), 5'($urandom_range(31)));
   endtask

   task automatic read_cell(input logic [4:0] row, input logic [4:0] col);
      send_req(ACT_READ, 8'($urandom_range(255)), row, col);
   endtask

   task automatic end_input();
      send_req(ACT_END, 8'($urandom_range(255)), 5'($urandom_range(31)),
               5'($urandom_range(31)));
   endtask

   // stop sending, wait for every read count, then let a last bump finish
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_counts.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_skip_header(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.skip_first_line = value;
      csr_wr_en   <= 1'b0;
   endtask

   // mostly common letters so the counts build up
   function automatic logic [4:0] pick_symbol();
      if ($urandom_range(9) < 5)
         return 5'($urandom_range(7));
      if ($urandom_range(9) < 8)
         return 5'($urandom_range(SYMBOLS - 1));
      return 5'($urandom_range(31));
   endfunction

   // text-shaped random request, with some noise
   task automatic random_request();
      int unsigned pick;
      int unsigned idx;
      pick = $urandom_range(99);
      if (pick < 58) begin
         idx = ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(25);
         feed($urandom_range(1) ? CHAR_UPPER_A + 8'(idx) : CHAR_LOWER_A + 8'(idx));
      end else if (pick < 68) begin
         // line end, sometimes with trailing carriage returns
         if ($urandom_range(9) < 4)
            repeat ($urandom_range(2, 1)) feed(CHAR_CR);
         feed(CHAR_LF);
      end else if (pick < 72) begin
         feed(CHAR_CR);
      end else if (pick < 80) begin
         feed(8'($urandom_range(255)));
      end else if (pick < 83) begin
         end_input();
      end else if (pick < 98) begin
         read_cell(pick_symbol(), pick_symbol());
      end else begin
         send_req(ACT_NONE, 8'($urandom_range(255)), 5'($urandom_range(31)),
                  5'($urandom_range(31)));
      end
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned stop_at;
      stop_at = sent_count + count;
      while (sent_count < stop_at)
         random_request();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_skip_header(1'b1);
      send_idle_pct = 9;
      rsp_idle_pct  = 56;

      // header line with letters and a carriage return is dropped
      feed("H"); feed("i"); feed(CHAR_CR); feed(CHAR_LF);
      // first byte, letter pair, last byte, trailing carriage returns
      feed("A"); feed("z"); feed(CHAR_CR); feed(CHAR_CR); feed(CHAR_LF);
      // carriage return inside a word breaks the pair
      feed("b"); feed(CHAR_CR); feed("c"); feed(CHAR_LF);
      // high and low bytes around a letter, closed by end of input
      feed(8'hFF); feed("Z"); feed(8'h00); end_input();
      // empty word, repeated end
      feed(CHAR_CR); feed(CHAR_LF); end_input();
      // reads: BOS pairs, EOS pairs, out-of-range indexes, ignored action
      read_cell(SYM_BOS, 5'd0);
      read_cell(5'd0, 5'd25);
      read_cell(5'd25, SYM_EOS);
      read_cell(5'd1, SYM_EOS);
      read_cell(SYM_EOS, SYM_BOS);
      read_cell(5'd31, 5'd31);
      read_cell(5'd28, 5'd0);
      send_req(ACT_NONE, 8'hFF, 5'd31, 5'd31);
      drain();

      // sender mostly busy, receiver often stalls
      write_skip_header(1'b0);
      random_phase(PHASE_ITEMS);
      drain();

      // the other way round
      write_skip_header(1'b1);
      send_idle_pct = 56;
      rsp_idle_pct  = 9;
      random_phase(PHASE_ITEMS);
      drain();

      // no idling; a long receiver hold first to back the block up
      write_skip_header(1'b0);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_go <= 1'b1;
      repeat (12) read_cell(pick_symbol(), pick_symbol());
      random_phase(PHASE_ITEMS);
      drain();

      if (sb.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
sv/lbh_pkg.sv
sv/lbh_ram.sv
sv/lbh_ctrl.sv
sv/lbh_datapath.sv
sv/letter_bigram_histogram.sv
dv/tb.sv
